[design/opv_pkg.sv]
package opv_pkg;

    // Fixed widths of the running sums
    localparam int AREA_BITS  = 64;
    localparam int HASH_BITS  = 32;
    localparam int COUNT_BITS = 3;

    // Running hash constants
    localparam logic [HASH_BITS-1:0] HASH_SEED = 32'd17;
    localparam logic [HASH_BITS-1:0] HASH_MULT = 32'd23;

    // Vertex count saturates here; a polygon needs at least MIN_VERTICES
    localparam logic [COUNT_BITS-1:0] COUNT_MAX    = 3'd7;
    localparam logic [COUNT_BITS-1:0] MIN_VERTICES = 3'd4;

    // Result status codes
    typedef enum logic [2:0] {
        STATUS_OK        = 3'd0,
        STATUS_FEW       = 3'd1,
        STATUS_EDGE      = 3'd2,
        STATUS_COLLINEAR = 3'd3,
        STATUS_ORIENT    = 3'd4
    } opv_status_t;

    // Per-vertex verdicts handed from the tracker to the result stage
    typedef struct packed {
        logic last;        // closing vertex of the polygon
        logic enough;      // at least MIN_VERTICES vertices seen
        logic edge_bad;    // some edge so far is diagonal or zero length
        logic collinear;   // some pair of adjacent edges is straight
    } opv_flags_t;

endpackage

[design/opv_vertex_if.sv]
interface opv_vertex_if #(
    parameter int COORD_BITS = 16
) ();

    logic                         valid;
    logic                         ready;
    logic signed [COORD_BITS-1:0] vertex_x;
    logic signed [COORD_BITS-1:0] vertex_y;
    logic                         final_vertex;

    modport source (
        output valid,
        output vertex_x,
        output vertex_y,
        output final_vertex,
        input  ready
    );

    modport sink (
        input  valid,
        input  vertex_x,
        input  vertex_y,
        input  final_vertex,
        output ready
    );

endinterface

[design/opv_result_if.sv]
interface opv_result_if #(
    parameter int COORD_BITS = 16
) ();

    logic                         valid;
    logic                         ready;
    logic [2:0]                   status;
    logic signed [COORD_BITS-1:0] box_min_x;
    logic signed [COORD_BITS-1:0] box_max_x;
    logic signed [COORD_BITS-1:0] box_min_y;
    logic signed [COORD_BITS-1:0] box_max_y;
    logic signed [31:0]           shape_hash;

    modport source (
        output valid,
        output status,
        output box_min_x,
        output box_max_x,
        output box_min_y,
        output box_max_y,
        output shape_hash,
        input  ready
    );

    modport sink (
        input  valid,
        input  status,
        input  box_min_x,
        input  box_max_x,
        input  box_min_y,
        input  box_max_y,
        input  shape_hash,
        output ready
    );

endinterface

[design/opv_track.sv]
module opv_track #(
    parameter int COORD_BITS = 16,
    parameter int PROD_BITS  = 2 * COORD_BITS + 2
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // vertex input
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic signed [COORD_BITS-1:0]  in_x,
    input  logic signed [COORD_BITS-1:0]  in_y,
    input  logic                          in_last,
    // toward the result stage
    output logic                          out_valid,
    input  logic                          out_ready,
    output opv_pkg::opv_flags_t           out_flags,
    output logic signed [PROD_BITS-1:0]   out_prod_edge,
    output logic signed [PROD_BITS-1:0]   out_prod_wrap,
    output logic signed [COORD_BITS-1:0]  out_min_x,
    output logic signed [COORD_BITS-1:0]  out_max_x,
    output logic signed [COORD_BITS-1:0]  out_min_y,
    output logic signed [COORD_BITS-1:0]  out_max_y,
    output logic [opv_pkg::HASH_BITS-1:0] out_hash
);

    import opv_pkg::*;

    localparam int WIDE_BITS = COORD_BITS + 1;

    // Input register
    logic                         in_valid_reg;
    logic signed [COORD_BITS-1:0] in_x_reg;
    logic signed [COORD_BITS-1:0] in_y_reg;
    logic                         in_last_reg;

    // Polygon tracking state
    logic signed [COORD_BITS-1:0] first_x_reg, first_y_reg;
    logic signed [COORD_BITS-1:0] second_x_reg, second_y_reg;
    logic signed [COORD_BITS-1:0] prior_x_reg, prior_y_reg;
    logic signed [COORD_BITS-1:0] older_x_reg, older_y_reg;
    logic signed [COORD_BITS-1:0] low_x_reg, high_x_reg, low_y_reg, high_y_reg;
    logic [COUNT_BITS-1:0]        count_reg, count_next;
    logic [HASH_BITS-1:0]         hash_reg, hash_next;
    logic                         edge_fault_reg, edge_fault_next;
    logic                         collinear_fault_reg, collinear_fault_next;

    // Stage output registers
    logic                         out_valid_reg;
    opv_flags_t                   flags_reg, flags_next;
    logic signed [PROD_BITS-1:0]  prod_edge_reg, prod_edge_next;
    logic signed [PROD_BITS-1:0]  prod_wrap_reg, prod_wrap_next;
    logic signed [COORD_BITS-1:0] min_x_next, max_x_next, min_y_next, max_y_next;

    logic                         stage_ready;
    logic                         in_fire;
    logic                         step_fire;
    logic                         is_first, is_second, has_two, has_three;
    logic                         step_edge_bad, step_straight;
    logic                         wrap_edge_bad, wrap_straight;
    logic signed [WIDE_BITS-1:0]  diff_edge, sum_edge, diff_wrap, sum_wrap;
    logic [HASH_BITS-1:0]         x_ext, y_ext;

    function automatic logic bad_edge(
        input logic signed [COORD_BITS-1:0] ax,
        input logic signed [COORD_BITS-1:0] ay,
        input logic signed [COORD_BITS-1:0] bx,
        input logic signed [COORD_BITS-1:0] by
    );
        return ((ax == bx) && (ay == by)) || ((ax != bx) && (ay != by));
    endfunction

    function automatic logic straight(
        input logic signed [COORD_BITS-1:0] ax,
        input logic signed [COORD_BITS-1:0] ay,
        input logic signed [COORD_BITS-1:0] bx,
        input logic signed [COORD_BITS-1:0] by,
        input logic signed [COORD_BITS-1:0] cx,
        input logic signed [COORD_BITS-1:0] cy
    );
        return ((ax == bx) && (bx == cx)) || ((ay == by) && (by == cy));
    endfunction

    // Handshake: each register moves when the one after it can take data
    assign stage_ready = !out_valid_reg || out_ready;
    assign in_ready    = !in_valid_reg || stage_ready;
    assign in_fire     = in_valid && in_ready;
    assign step_fire   = in_valid_reg && stage_ready;

    assign is_first  = (count_reg == '0);
    assign is_second = (count_reg == COUNT_BITS'(1));
    assign has_two   = (count_reg >= COUNT_BITS'(2));
    assign has_three = (count_reg >= MIN_VERTICES - COUNT_BITS'(1));

    // Edge and triple checks, per vertex and around the wrap
    always_comb
    begin
        step_edge_bad = !is_first && bad_edge(prior_x_reg, prior_y_reg, in_x_reg, in_y_reg);
        step_straight = has_two && straight(older_x_reg, older_y_reg, prior_x_reg,
                                            prior_y_reg, in_x_reg, in_y_reg);
        wrap_edge_bad = bad_edge(in_x_reg, in_y_reg, first_x_reg, first_y_reg);
        wrap_straight = straight(prior_x_reg, prior_y_reg, in_x_reg, in_y_reg,
                                 first_x_reg, first_y_reg)
                     || straight(in_x_reg, in_y_reg, first_x_reg, first_y_reg,
                                 second_x_reg, second_y_reg);
    end

    // Shoelace terms: (x - px) * (y + py) for this edge and the closing edge
    always_comb
    begin
        diff_edge = WIDE_BITS'(in_x_reg) - WIDE_BITS'(prior_x_reg);
        sum_edge  = WIDE_BITS'(in_y_reg) + WIDE_BITS'(prior_y_reg);
        diff_wrap = WIDE_BITS'(first_x_reg) - WIDE_BITS'(in_x_reg);
        sum_wrap  = WIDE_BITS'(first_y_reg) + WIDE_BITS'(in_y_reg);
        prod_edge_next = is_first ? '0 : PROD_BITS'(diff_edge * sum_edge);
        prod_wrap_next = (in_last_reg && has_three) ? PROD_BITS'(diff_wrap * sum_wrap) : '0;
    end

    // Bounding box, hash, count and fault flags after this vertex
    always_comb
    begin
        if (is_first)
        begin
            min_x_next = in_x_reg;
            max_x_next = in_x_reg;
            min_y_next = in_y_reg;
            max_y_next = in_y_reg;
        end
        else
        begin
            min_x_next = (in_x_reg < low_x_reg)  ? in_x_reg : low_x_reg;
            max_x_next = (in_x_reg > high_x_reg) ? in_x_reg : high_x_reg;
            min_y_next = (in_y_reg < low_y_reg)  ? in_y_reg : low_y_reg;
            max_y_next = (in_y_reg > high_y_reg) ? in_y_reg : high_y_reg;
        end
        x_ext = HASH_BITS'(in_x_reg);
        y_ext = HASH_BITS'(in_y_reg);
        hash_next  = HASH_BITS'(hash_reg * HASH_MULT) + x_ext + y_ext;
        count_next = (count_reg == COUNT_MAX) ? count_reg : count_reg + COUNT_BITS'(1);
        edge_fault_next      = edge_fault_reg | step_edge_bad;
        collinear_fault_next = collinear_fault_reg | step_straight;

        flags_next.last      = in_last_reg;
        flags_next.enough    = has_three;
        flags_next.edge_bad  = edge_fault_next | (has_three & wrap_edge_bad);
        flags_next.collinear = collinear_fault_next | (has_three & wrap_straight);
    end

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            in_x_reg    <= in_x;
            in_y_reg    <= in_y;
            in_last_reg <= in_last;
        end
    end

    // Control state; clears itself on the closing vertex
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg       <= 1'b0;
            count_reg           <= '0;
            hash_reg            <= HASH_SEED;
            edge_fault_reg      <= 1'b0;
            collinear_fault_reg <= 1'b0;
        end
        else
        begin
            if (stage_ready)
            begin
                out_valid_reg <= in_valid_reg;
            end
            if (step_fire)
            begin
                if (in_last_reg)
                begin
                    count_reg           <= '0;
                    hash_reg            <= HASH_SEED;
                    edge_fault_reg      <= 1'b0;
                    collinear_fault_reg <= 1'b0;
                end
                else
                begin
                    count_reg           <= count_next;
                    hash_reg            <= hash_next;
                    edge_fault_reg      <= edge_fault_next;
                    collinear_fault_reg <= collinear_fault_next;
                end
            end
        end
    end

    // Vertex history, box and stage payload
    always_ff @(posedge clk)
    begin
        if (step_fire)
        begin
            if (is_first)
            begin
                first_x_reg <= in_x_reg;
                first_y_reg <= in_y_reg;
            end
            if (is_second)
            begin
                second_x_reg <= in_x_reg;
                second_y_reg <= in_y_reg;
            end
            older_x_reg   <= prior_x_reg;
            older_y_reg   <= prior_y_reg;
            prior_x_reg   <= in_x_reg;
            prior_y_reg   <= in_y_reg;
            low_x_reg     <= min_x_next;
            high_x_reg    <= max_x_next;
            low_y_reg     <= min_y_next;
            high_y_reg    <= max_y_next;
            flags_reg     <= flags_next;
            prod_edge_reg <= prod_edge_next;
            prod_wrap_reg <= prod_wrap_next;
            out_hash      <= hash_next;
            out_min_x     <= min_x_next;
            out_max_x     <= max_x_next;
            out_min_y     <= min_y_next;
            out_max_y     <= max_y_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign out_flags     = flags_reg;
    assign out_prod_edge = prod_edge_reg;
    assign out_prod_wrap = prod_wrap_reg;

endmodule

[design/opv_judge.sv]
module opv_judge #(
    parameter int COORD_BITS = 16,
    parameter int PROD_BITS  = 2 * COORD_BITS + 2
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // from the tracker
    input  logic                          in_valid,
    output logic                          in_ready,
    input  opv_pkg::opv_flags_t           in_flags,
    input  logic signed [PROD_BITS-1:0]   in_prod_edge,
    input  logic signed [PROD_BITS-1:0]   in_prod_wrap,
    input  logic signed [COORD_BITS-1:0]  in_min_x,
    input  logic signed [COORD_BITS-1:0]  in_max_x,
    input  logic signed [COORD_BITS-1:0]  in_min_y,
    input  logic signed [COORD_BITS-1:0]  in_max_y,
    input  logic [opv_pkg::HASH_BITS-1:0] in_hash,
    // result output
    output logic                          res_valid,
    input  logic                          res_ready,
    output logic [2:0]                    res_status,
    output logic signed [COORD_BITS-1:0]  res_min_x,
    output logic signed [COORD_BITS-1:0]  res_max_x,
    output logic signed [COORD_BITS-1:0]  res_min_y,
    output logic signed [COORD_BITS-1:0]  res_max_y,
    output logic signed [31:0]            res_hash
);

    import opv_pkg::*;

    localparam int PAD_BITS = AREA_BITS - PROD_BITS + 1;

    logic signed [AREA_BITS-1:0] area_reg;
    logic signed [AREA_BITS-1:0] area_total;
    logic signed [AREA_BITS-1:0] term_edge, term_wrap;
    logic                        res_valid_reg;
    opv_status_t                 status_reg, status_next;
    logic                        take;

    assign in_ready = !res_valid_reg || res_ready;
    assign take     = in_valid && in_ready;

    // Area sum including this vertex's terms
    always_comb
    begin
        term_edge  = {{PAD_BITS{in_prod_edge[PROD_BITS-1]}}, in_prod_edge[PROD_BITS-2:0]};
        term_wrap  = {{PAD_BITS{in_prod_wrap[PROD_BITS-1]}}, in_prod_wrap[PROD_BITS-2:0]};
        area_total = area_reg + term_edge + term_wrap;
    end

    // Status priority: too few, bad edge, collinear, orientation
    always_comb
    begin
        if (!in_flags.enough)
        begin
            status_next = STATUS_FEW;
        end
        else if (in_flags.edge_bad)
        begin
            status_next = STATUS_EDGE;
        end
        else if (in_flags.collinear)
        begin
            status_next = STATUS_COLLINEAR;
        end
        else if ((area_total == '0) || area_total[AREA_BITS-1])
        begin
            status_next = STATUS_ORIENT;
        end
        else
        begin
            status_next = STATUS_OK;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
            area_reg      <= '0;
        end
        else
        begin
            if (take)
            begin
                res_valid_reg <= in_flags.last;
                area_reg      <= in_flags.last ? '0 : area_total;
            end
            else if (res_ready)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        if (take && in_flags.last)
        begin
            status_reg <= status_next;
            res_min_x  <= in_min_x;
            res_max_x  <= in_max_x;
            res_min_y  <= in_min_y;
            res_max_y  <= in_max_y;
            res_hash   <= in_hash;
        end
    end

    assign res_valid  = res_valid_reg;
    assign res_status = status_reg;

endmodule

[design/orthogonal_polygon_validator.sv]
// Orthogonal polygon validator.
// vertex channel: one transfer per polygon vertex, in order; final_vertex marks
//   the closing vertex. A vertex can be taken in every cycle unless a receiver stall backs up to it.
// result channel: one transfer per polygon, after its closing vertex: status
//   (ok, too few points, bad edge, collinear edges, not clockwise), bounding
//   box and shape hash. Box and hash are valid for every status.
// Path: a closing vertex passes the input register, the tracking stage and the
//   result register before its result is valid. Throughput is one vertex per
//   cycle while the result receiver does not stall.
// Reset: valids drop, the vertex count, fault flags and area sum clear and the
//   hash reloads its seed. Each polygon also clears this state when it closes.
// Receiver stall: the result register holds; vertices behind it keep moving
//   until the input and tracking registers are full, then vertex ready drops.
module orthogonal_polygon_validator #(
    parameter int COORD_BITS = 16
) (
    input  logic                     clk,
    input  logic                     rst_n,
    opv_vertex_if.sink               vertex,
    opv_result_if.source             result
);

    import opv_pkg::*;

    localparam int PROD_BITS = 2 * COORD_BITS + 2;

    logic                         step_valid;
    logic                         step_ready;
    opv_flags_t                   step_flags;
    logic signed [PROD_BITS-1:0]  step_prod_edge;
    logic signed [PROD_BITS-1:0]  step_prod_wrap;
    logic signed [COORD_BITS-1:0] step_min_x, step_max_x, step_min_y, step_max_y;
    logic [HASH_BITS-1:0]         step_hash;

    // Per-vertex tracking
    opv_track #(
        .COORD_BITS (COORD_BITS),
        .PROD_BITS  (PROD_BITS)
    ) u_track (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (vertex.valid),
        .in_ready      (vertex.ready),
        .in_x          (vertex.vertex_x),
        .in_y          (vertex.vertex_y),
        .in_last       (vertex.final_vertex),
        .out_valid     (step_valid),
        .out_ready     (step_ready),
        .out_flags     (step_flags),
        .out_prod_edge (step_prod_edge),
        .out_prod_wrap (step_prod_wrap),
        .out_min_x     (step_min_x),
        .out_max_x     (step_max_x),
        .out_min_y     (step_min_y),
        .out_max_y     (step_max_y),
        .out_hash      (step_hash)
    );

    // Area accumulation and result register
    opv_judge #(
        .COORD_BITS (COORD_BITS),
        .PROD_BITS  (PROD_BITS)
    ) u_judge (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (step_valid),
        .in_ready     (step_ready),
        .in_flags     (step_flags),
        .in_prod_edge (step_prod_edge),
        .in_prod_wrap (step_prod_wrap),
        .in_min_x     (step_min_x),
        .in_max_x     (step_max_x),
        .in_min_y     (step_min_y),
        .in_max_y     (step_max_y),
        .in_hash      (step_hash),
        .res_valid    (result.valid),
        .res_ready    (result.ready),
        .res_status   (result.status),
        .res_min_x    (result.box_min_x),
        .res_max_x    (result.box_max_x),
        .res_min_y    (result.box_min_y),
        .res_max_y    (result.box_max_y),
        .res_hash     (result.shape_hash)
    );

endmodule

[dv/tb_top.sv]
module tb_top;
    import opv_pkg::*;

    typedef logic signed [15:0] coord_t;

    typedef struct packed {
        coord_t x;
        coord_t y;
    } point_t;

    // One polygon verdict as it leaves the block
    typedef struct packed {
        logic [2:0]  status;
        coord_t      min_x;
        coord_t      max_x;
        coord_t      min_y;
        coord_t      max_y;
        logic [31:0] hash;
    } verdict_t;

    // Tracks the open polygon and keeps the verdicts still owed by the block
    class polygon_scoreboard;
        localparam int HASH_START = 17;
        localparam int HASH_STEP  = 23;
        localparam int COUNT_TOP  = 7;
        localparam int FEW_LIMIT  = 4;

        verdict_t owed_q[$];
        int       mismatches;

        coord_t   first_x, first_y, second_x, second_y;
        coord_t   prior_x, prior_y, older_x, older_y;
        coord_t   lo_x, hi_x, lo_y, hi_y;
        int       seen;
        longint   area;
        int       hash;
        bit       edge_bad;
        bit       line_bad;

        function new();
            mismatches = 0;
            clear();
        endfunction

        function void clear();
            seen     = 0;
            area     = 0;
            hash     = HASH_START;
            edge_bad = 1'b0;
            line_bad = 1'b0;
        endfunction

        function int pending();
            return owed_q.size();
        endfunction

        // Diagonal or zero-length edge
        static function bit crooked(coord_t ax, coord_t ay, coord_t bx, coord_t by);
            if (ax == bx && ay == by)
                return 1'b1;
            return ax != bx && ay != by;
        endfunction

        // Two adjacent edges both vertical or both horizontal
        static function bit in_line(coord_t ax, coord_t ay, coord_t bx, coord_t by,
                                    coord_t cx, coord_t cy);
            return (ax == bx && bx == cx) || (ay == by && by == cy);
        endfunction

        function void add_area(coord_t px, coord_t py, coord_t x, coord_t y);
            area += (longint'(x) - longint'(px)) * (longint'(y) + longint'(py));
        endfunction

        function void note_vertex(coord_t x, coord_t y, logic last);
            verdict_t v;
            int       was;
            was = seen;
            if (was == 0)
            begin
                first_x = x;
                first_y = y;
                lo_x = x;
                hi_x = x;
                lo_y = y;
                hi_y = y;
            end
            else
            begin
                if (was == 1)
                begin
                    second_x = x;
                    second_y = y;
                end
                if (x < lo_x) lo_x = x;
                if (x > hi_x) hi_x = x;
                if (y < lo_y) lo_y = y;
                if (y > hi_y) hi_y = y;
                if (crooked(prior_x, prior_y, x, y))
                    edge_bad = 1'b1;
                add_area(prior_x, prior_y, x, y);
                if (was >= 2 && in_line(older_x, older_y, prior_x, prior_y, x, y))
                    line_bad = 1'b1;
            end
            hash = hash * HASH_STEP + int'(x) + int'(y);
            if (was < COUNT_TOP)
                seen = was + 1;

            if (!last)
            begin
                older_x = prior_x;
                older_y = prior_y;
                prior_x = x;
                prior_y = y;
                return;
            end

            // Closing vertex: wrap-around edge and triples, then the verdict
            if (seen < FEW_LIMIT)
                v.status = STATUS_FEW;
            else
            begin
                if (crooked(x, y, first_x, first_y))
                    edge_bad = 1'b1;
                add_area(x, y, first_x, first_y);
                if (in_line(prior_x, prior_y, x, y, first_x, first_y) ||
                    in_line(x, y, first_x, first_y, second_x, second_y))
                    line_bad = 1'b1;
                if (edge_bad)
                    v.status = STATUS_EDGE;
                else if (line_bad)
                    v.status = STATUS_COLLINEAR;
                else if (area <= 0)
                    v.status = STATUS_ORIENT;
                else
                    v.status = STATUS_OK;
            end
            v.min_x = lo_x;
            v.max_x = hi_x;
            v.min_y = lo_y;
            v.max_y = hi_y;
            v.hash  = hash;
            owed_q.insert(owed_q.size(), v);
            clear();
        endfunction

        function void check_result(verdict_t got);
            verdict_t want;
            if (owed_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: result transfer with none owed: status %0d hash %h",
                             $time, got.status, got.hash);
                return;
            end
            want = owed_q.pop_front();
            if (got.status !== want.status || got.min_x !== want.min_x ||
                got.max_x !== want.max_x || got.min_y !== want.min_y ||
                got.max_y !== want.max_y || got.hash !== want.hash)
            begin
                mismatches++;
                if (mismatches <= 10)
                begin
                    $display("%0t: verdict mismatch", $time);
                    $display("  expected status %0d x[%0d,%0d] y[%0d,%0d] hash %h",
                             want.status, want.min_x, want.max_x, want.min_y, want.max_y,
                             want.hash);
                    $display("  actual   status %0d x[%0d,%0d] y[%0d,%0d] hash %h",
                             got.status, got.min_x, got.max_x, got.min_y, got.max_y,
                             got.hash);
                end
            end
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n;

    opv_vertex_if #(.COORD_BITS(16)) vertex_bus ();
    opv_result_if #(.COORD_BITS(16)) result_bus ();

    orthogonal_polygon_validator #(.COORD_BITS(16)) dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .vertex (vertex_bus),
        .result (result_bus)
    );

    polygon_scoreboard board;
    point_t            shape_q[$];
    int                send_idle_pct;
    int                recv_idle_pct;
    int                vertices_sent;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Receiver: random stalls, decided at the falling edge
    always @(negedge clk)
        result_bus.ready <= ($urandom_range(0, 99) >= recv_idle_pct);

    // Result transfers, sampled at the rising edge
    always @(posedge clk)
    begin : result_monitor
        verdict_t got;
        if (rst_n && result_bus.valid === 1'b1 && result_bus.ready === 1'b1)
        begin
            got.status = result_bus.status;
            got.min_x  = result_bus.box_min_x;
            got.max_x  = result_bus.box_max_x;
            got.min_y  = result_bus.box_min_y;
            got.max_y  = result_bus.box_max_y;
            got.hash   = result_bus.shape_hash;
            board.check_result(got);
        end
    end

    // Called at a falling edge; returns at the falling edge after the transfer
    task automatic send_vertex(coord_t x, coord_t y, logic last);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            vertex_bus.valid <= 1'b0;
            @(negedge clk);
        end
        vertex_bus.valid        <= 1'b1;
        vertex_bus.vertex_x     <= x;
        vertex_bus.vertex_y     <= y;
        vertex_bus.final_vertex <= last;
        @(posedge clk);
        while (vertex_bus.ready !== 1'b1)
            @(posedge clk);
        board.note_vertex(x, y, last);
        vertices_sent++;
        @(negedge clk);
    endtask

    task automatic send_shape();
        foreach (shape_q[i])
            send_vertex(shape_q[i].x, shape_q[i].y, i == shape_q.size() - 1);
    endtask

    // Hold the sender off until every owed verdict has come back
    task automatic drain();
        vertex_bus.valid <= 1'b0;
        @(negedge clk);
        while (board.pending() != 0)
            @(negedge clk);
    endtask

    function automatic void push_pt(int x, int y);
        point_t p;
        p.x = 16'(x);
        p.y = 16'(y);
        shape_q.insert(shape_q.size(), p);
    endfunction

    // Mix of full range, tight clusters, extremes and a mid range
    function automatic coord_t pick_coord();
        case ($urandom_range(0, 3))
            0: return 16'($urandom);
            1: return 16'($urandom_range(0, 16)) - 16'sd8;
            2:
            begin
                case ($urandom_range(0, 3))
                    0: return 16'sh8000;
                    1: return 16'sh7fff;
                    2: return 16'sh0000;
                    default: return 16'shffff;
                endcase
            end
            default: return 16'($urandom_range(0, 600)) - 16'sd300;
        endcase
    endfunction

    // Alternating horizontal/vertical outline with k x and y steps, each differing from the one before
    function automatic void make_orthogonal(int k);
        coord_t xs[$];
        coord_t ys[$];
        point_t ring[$];
        point_t p;
        coord_t c;
        int     rot;
        shape_q.delete();
        for (int i = 0; i < k; i++)
        begin
            do c = pick_coord();
            while ((i > 0 && c == xs[i-1]) || (i == k - 1 && c == xs[0]));
            xs.insert(xs.size(), c);
            do c = pick_coord();
            while ((i > 0 && c == ys[i-1]) || (i == k - 1 && c == ys[0]));
            ys.insert(ys.size(), c);
        end
        for (int i = 0; i < k; i++)
        begin
            p.x = xs[i];
            p.y = ys[i];
            ring.insert(ring.size(), p);
            p.x = xs[(i + 1) % k];
            ring.insert(ring.size(), p);
        end
        rot = $urandom_range(0, 2 * k - 1);
        for (int j = 0; j < 2 * k; j++)
            shape_q.insert(shape_q.size(), ring[(j + rot) % (2 * k)]);
        if ($urandom_range(0, 1))
            shape_q.reverse();
    endfunction

    // Break an outline: diagonal, zero-length, straight run or too few points
    function automatic void damage_shape();
        int     j;
        int     keep;
        point_t a;
        point_t b;
        point_t mid;
        j = $urandom_range(0, shape_q.size() - 1);
        case ($urandom_range(0, 3))
            0: shape_q[j].x = pick_coord();
            1: shape_q.insert(j, shape_q[j]);
            2:
            begin
                a = shape_q[j];
                b = shape_q[(j + 1) % shape_q.size()];
                mid.x = 16'((int'(a.x) + int'(b.x)) / 2);
                mid.y = 16'((int'(a.y) + int'(b.y)) / 2);
                if (j == shape_q.size() - 1)
                    shape_q.insert(shape_q.size(), mid);
                else
                    shape_q.insert(j + 1, mid);
            end
            default:
            begin
                keep = $urandom_range(1, 3);
                while (shape_q.size() > keep)
                    shape_q.pop_back();
            end
        endcase
    endfunction

    task automatic run_directed();
        // lone vertex at the corner of the range
        shape_q.delete(); push_pt(-32768, 32767); send_shape();
        // three vertices
        shape_q.delete(); push_pt(32767, -32768); push_pt(0, -32768); push_pt(0, 0);
        send_shape();
        // full-range clockwise rectangle
        shape_q.delete();
        push_pt(-32768, -32768); push_pt(-32768, 32767);
        push_pt(32767, 32767);   push_pt(32767, -32768);
        send_shape();
        // counter-clockwise square
        shape_q.delete(); push_pt(0, 0); push_pt(10, 0); push_pt(10, 10); push_pt(0, 10);
        send_shape();
        // diagonal closing edge
        shape_q.delete(); push_pt(0, 0); push_pt(0, 5); push_pt(5, 5); push_pt(5, 1);
        send_shape();
        // straight run in the middle
        shape_q.delete();
        push_pt(0, 0); push_pt(0, 3); push_pt(0, 6); push_pt(4, 6); push_pt(4, 0);
        send_shape();
        // straight run through the closing vertex
        shape_q.delete();
        push_pt(0, 0); push_pt(0, 5); push_pt(5, 5); push_pt(5, 0); push_pt(3, 0);
        send_shape();
    endtask

    task automatic run_random(int count);
        int goal;
        int pick;
        int k;
        int n;
        goal = vertices_sent + count;
        while (vertices_sent < goal)
        begin
            pick = $urandom_range(0, 99);
            k = ($urandom_range(0, 7) == 0) ? $urandom_range(5, 10) : $urandom_range(2, 4);
            if (pick < 90)
            begin
                make_orthogonal(k);
                if (pick >= 70)
                    damage_shape();
                send_shape();
            end
            else
            begin
                // loose vertices, closing now and then
                n = $urandom_range(1, 6);
                for (int i = 0; i < n; i++)
                    send_vertex(pick_coord(), pick_coord(), $urandom_range(0, 3) == 0);
            end
        end
    endtask

    initial
    begin
        rst_n                   = 1'b0;
        vertex_bus.valid        = 1'b0;
        vertex_bus.vertex_x     = '0;
        vertex_bus.vertex_y     = '0;
        vertex_bus.final_vertex = 1'b0;
        result_bus.ready        = 1'b0;
        send_idle_pct           = 21;
        recv_idle_pct           = 64;
        vertices_sent           = 0;
        board                   = new();
        repeat (10) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        run_directed();
        run_random(630);
        drain();

        send_idle_pct = 64;
        recv_idle_pct = 21;
        run_random(630);
        drain();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        run_random(630);
        drain();
        repeat (10) @(negedge clk);

        if (board.mismatches == 0 && board.pending() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    // Watchdog
    initial
    begin
        #3000000;
        $display("TB_ERROR");
        $finish;
    end

endmodule

[filelist.f]
design/opv_pkg.sv
design/opv_vertex_if.sv
design/opv_result_if.sv
design/opv_track.sv
design/opv_judge.sv
design/orthogonal_polygon_validator.sv
dv/tb_top.sv
